// ----- src/teq_pkg.sv -----
// ---------------------------------------------------------------------------
// teq_pkg: shared types and constants for the timer event queue
// Sizes, opcodes, error codes and the controller/datapath command struct.
// ---------------------------------------------------------------------------
`default_nettype none

package teq_pkg;

	localparam int MaxEvents    = 16;
	localparam int TimeBits     = 48;
	localparam int PriorityBits = 8;
	localparam int IdBits       = 4;
	localparam int SlotBits     = $clog2(MaxEvents);
	localparam int PeriodBits   = 31;
	localparam int CountBits    = 32;
	localparam int DueBits      = TimeBits + 1;

	localparam logic [1:0] OpCreate  = 2'd0;
	localparam logic [1:0] OpRemove  = 2'd1;
	localparam logic [1:0] OpGetNext = 2'd2;
	localparam logic [1:0] OpSetTime = 2'd3;

	localparam logic [1:0] ErrNone     = 2'd0;
	localparam logic [1:0] ErrOccupied = 2'd1;
	localparam logic [1:0] ErrEmpty    = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // capture input word, do create/remove/set-time
		logic clr_scan;   // reset scan accumulators and slot index
		logic promote;    // pass: move due timers into ready set
		logic select;     // pass: find minimum ready key and idle minimum
		logic step;       // advance slot index
		logic pop;        // pop the chosen slot
		logic finish;     // load the result register
	} teq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_getnext;
		logic last_slot;
		logic any_ready;
		logic popped;     // pop step of this word already done
	} teq_sts_t;

endpackage

`default_nettype wire

// ----- src/teq_ctrl.sv -----
// ---------------------------------------------------------------------------
// teq_ctrl: sequencer of the timer event queue
// Runs one word through load, an optional promote pass, select passes, a pop for get-next, result.
// ---------------------------------------------------------------------------
`default_nettype none

module teq_ctrl import teq_pkg::*; (
	input  wire  logic     clk,
	input  wire  logic     arst_n,
	input  wire  logic     in_fire,
	input  wire  logic     out_free,
	input  wire  teq_sts_t sts,
	output teq_cmd_t       cmd,
	output logic           busy
);

	typedef enum logic [6:0] {
		StIdle    = 7'b0000001,
		StLoad    = 7'b0000010,
		StPromote = 7'b0000100,
		StPrep    = 7'b0001000,
		StSelect  = 7'b0010000,
		StPop     = 7'b0100000,
		StDone    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			StIdle: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = StLoad;
				end
			end
			StLoad: begin
				cmd.clr_scan = 1'b1;
				if (!sts.is_getnext) state_d = StPrep;
				else if (sts.any_ready) state_d = StPrep;
				else state_d = StPromote;
			end
			StPromote: begin
				cmd.promote = 1'b1;
				cmd.step    = 1'b1;
				if (sts.last_slot) state_d = StPrep;
			end
			StPrep: begin
				cmd.clr_scan = 1'b1;
				state_d      = StSelect;
			end
			StSelect: begin
				cmd.select = 1'b1;
				cmd.step   = 1'b1;
				if (sts.last_slot)
					state_d = (sts.is_getnext && !sts.popped) ? StPop : StDone;
			end
			StPop: begin
				cmd.pop = 1'b1;
				cmd.clr_scan = 1'b1;
				state_d = StSelect;
			end
			StDone: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= StIdle;
		else state_q <= state_d;
	end

	assign busy = (state_q != StIdle);

endmodule

`default_nettype wire

// ----- src/teq_dp.sv -----
// ---------------------------------------------------------------------------
// teq_dp: slot table and scan datapath of the timer event queue
// Holds the slots, walks them one per cycle, tracks minima, pops and
// reschedules the chosen event.
// ---------------------------------------------------------------------------
`default_nettype none

module teq_dp import teq_pkg::*; (
	input  wire  logic                    clk,
	input  wire  logic                    arst_n,
	input  wire  teq_cmd_t                cmd,
	input  wire  logic [1:0]              opcode,
	input  wire  logic [IdBits-1:0]       event_id,
	input  wire  logic [PeriodBits-1:0]   period,
	input  wire  logic [PriorityBits-1:0] priority_req,
	input  wire  logic                    continuous,
	input  wire  logic [TimeBits-1:0]     time_value,
	output teq_sts_t                      sts,
	output logic                          res_valid,
	output logic [IdBits-1:0]             res_id,
	output logic [PeriodBits-1:0]         res_idle,
	output logic [CountBits-1:0]          res_count,
	output logic [1:0]                    res_err
);

	localparam logic [PeriodBits-1:0] IdleMax = '1;

	logic [MaxEvents-1:0]    valid_q, ready_q;
	logic [DueBits-1:0]      due_q      [MaxEvents];
	logic [PriorityBits-1:0] prio_q     [MaxEvents];
	logic [PeriodBits-1:0]   period_q   [MaxEvents];
	logic [MaxEvents-1:0]    repeat_q;
	logic [CountBits-1:0]    arrival_q  [MaxEvents];
	logic [CountBits-1:0]    arr_cnt_q, rdy_cnt_q;
	logic [TimeBits-1:0]     now_q;

	logic [1:0]              op_q;
	logic                    popped_q;
	logic [1:0]              err_q;
	logic [SlotBits-1:0]     idx_q;
	logic                    found_q;
	logic [SlotBits-1:0]     pick_q;
	logic                    anyrdy_q;
	logic                    have_t_q;
	logic [DueBits-1:0]      min_due_q;
	logic                    o_valid_q;
	logic [IdBits-1:0]       o_id_q;

	// current slot view
	logic [DueBits-1:0]      c_due;
	logic                    c_vr, c_vt, c_before, in_range;
	logic [DueBits-1:0]      sched_due, idle_diff;

	assign in_range = ({1'b0, event_id} < (IdBits+1)'(MaxEvents));
	assign c_due    = due_q[idx_q];
	assign c_vr     = valid_q[idx_q] & ready_q[idx_q];
	assign c_vt     = valid_q[idx_q] & ~ready_q[idx_q];
	always_comb begin
		if (c_due != due_q[pick_q]) c_before = c_due < due_q[pick_q];
		else if (prio_q[idx_q] != prio_q[pick_q]) c_before = prio_q[idx_q] < prio_q[pick_q];
		else c_before = arrival_q[idx_q] < arrival_q[pick_q];
	end

	assign sts.is_getnext = (op_q == OpGetNext);
	assign sts.last_slot  = (idx_q == SlotBits'(MaxEvents-1));
	assign sts.any_ready  = |(valid_q & ready_q);
	assign sts.popped     = popped_q;

	assign sched_due = {1'b0, now_q} + DueBits'(period_q[pick_q]);
	assign idle_diff = min_due_q - {1'b0, now_q};

	// slot table and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			ready_q   <= '0;
			arr_cnt_q <= '0;
			rdy_cnt_q <= '0;
			now_q     <= '0;
			op_q      <= OpSetTime;
			err_q     <= ErrNone;
			popped_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q     <= opcode;
				err_q    <= ErrNone;
				popped_q <= 1'b0;
				case (opcode)
					OpCreate: begin
						if (!in_range || valid_q[event_id[SlotBits-1:0]]) begin
							err_q <= ErrOccupied;
						end else begin
							valid_q[event_id[SlotBits-1:0]]  <= 1'b1;
							period_q[event_id[SlotBits-1:0]] <= period;
							prio_q[event_id[SlotBits-1:0]]   <= priority_req;
							repeat_q[event_id[SlotBits-1:0]] <= continuous;
							due_q[event_id[SlotBits-1:0]]    <=
								{1'b0, now_q} + DueBits'(period);
							arrival_q[event_id[SlotBits-1:0]] <= arr_cnt_q;
							arr_cnt_q <= arr_cnt_q + 1'b1;
							ready_q[event_id[SlotBits-1:0]]  <= (period == '0);
							if (period == '0) rdy_cnt_q <= rdy_cnt_q + 1'b1;
						end
					end
					OpRemove: begin
						if (!in_range || !valid_q[event_id[SlotBits-1:0]]) begin
							err_q <= ErrEmpty;
						end else begin
							valid_q[event_id[SlotBits-1:0]] <= 1'b0;
							ready_q[event_id[SlotBits-1:0]] <= 1'b0;
						end
					end
					OpSetTime: now_q <= time_value;
					default: ;
				endcase
			end
			// promote one due timer
			if (cmd.promote && c_vt && c_due <= {1'b0, now_q}) begin
				ready_q[idx_q] <= 1'b1;
				rdy_cnt_q      <= rdy_cnt_q + 1'b1;
			end
			// pop or requeue the chosen slot, once
			if (cmd.pop) begin
				popped_q <= 1'b1;
				if (found_q && !popped_q) begin
					if (repeat_q[pick_q]) begin
						due_q[pick_q]     <= sched_due;
						arrival_q[pick_q] <= arr_cnt_q;
						arr_cnt_q         <= arr_cnt_q + 1'b1;
						ready_q[pick_q]   <= (period_q[pick_q] == '0);
						if (period_q[pick_q] == '0) rdy_cnt_q <= rdy_cnt_q + 1'b1;
					end else begin
						valid_q[pick_q] <= 1'b0;
						ready_q[pick_q] <= 1'b0;
					end
				end
			end
		end
	end

	// scan accumulators; second select pass after pop computes idle time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			found_q   <= 1'b0;
			pick_q    <= '0;
			anyrdy_q  <= 1'b0;
			have_t_q  <= 1'b0;
			min_due_q <= '0;
			o_valid_q <= 1'b0;
			o_id_q    <= '0;
		end else begin
			if (cmd.load) begin
				o_valid_q <= 1'b0;
				o_id_q    <= '0;
			end
			if (cmd.pop && !popped_q && found_q) begin
				o_valid_q <= 1'b1;
				o_id_q    <= IdBits'(pick_q);
			end
			if (cmd.clr_scan) begin
				idx_q    <= '0;
				anyrdy_q <= 1'b0;
				have_t_q <= 1'b0;
				found_q  <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.select) begin
				if (c_vr) begin
					anyrdy_q <= 1'b1;
					if (!found_q || c_before) begin
						pick_q  <= idx_q;
						found_q <= 1'b1;
					end
				end
				if (c_vt && (!have_t_q || c_due < min_due_q)) begin
					min_due_q <= c_due;
					have_t_q  <= 1'b1;
				end
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_valid <= o_valid_q;
			res_id    <= o_id_q;
			res_count <= rdy_cnt_q;
			res_err   <= err_q;
			if (anyrdy_q) res_idle <= '0;
			else if (!have_t_q) res_idle <= IdleMax;
			else if (min_due_q <= {1'b0, now_q}) res_idle <= '0;
			else if (idle_diff > DueBits'(IdleMax)) res_idle <= IdleMax;
			else res_idle <= idle_diff[PeriodBits-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- src/timer_event_queue.sv -----
// Create, remove and set-time words run through load, a select sweep and the
// result; get-next adds an optional promote sweep, a pop and a final sweep
// for the idle time, one slot per cycle. One word at a time: the next word
// is accepted only after the result is loaded, which waits out any output
// stall. Reset (arst_n low) empties the table and clears the time, arrival
// and ready counters at once; no clearing pass.
// ---------------------------------------------------------------------------
// timer_event_queue: top level of the sorted timer event queue
// Joins the sequencer, the slot datapath and an output register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module timer_event_queue import teq_pkg::*; (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_tvalid,
	output logic              s_tready,
	// opcode[1:0] event_id[5:2] period[36:6] priority_req[44:37]
	// continuous[45] time_value[93:46], zero to 95
	input  wire  logic [95:0] s_tdata,
	output logic              m_tvalid,
	input  wire  logic        m_tready,
	// event_valid[0] event_id_out[4:1] idle_time[35:5] ready_count[67:36]
	// error_code[69:68], zero to 71
	output logic [71:0]       m_tdata
);

	teq_cmd_t cmd;
	teq_sts_t sts;
	logic     busy, in_fire, out_free;
	logic     rv;
	logic [IdBits-1:0]     rid;
	logic [PeriodBits-1:0] ridle;
	logic [CountBits-1:0]  rcnt;
	logic [1:0]            rerr;
	logic                  m_valid_q;

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	teq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	teq_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.opcode(s_tdata[1:0]), .event_id(s_tdata[5:2]), .period(s_tdata[36:6]),
		.priority_req(s_tdata[44:37]), .continuous(s_tdata[45]),
		.time_value(s_tdata[93:46]), .sts(sts),
		.res_valid(rv), .res_id(rid), .res_idle(ridle), .res_count(rcnt), .res_err(rerr)
	);

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (cmd.finish) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, rerr, rcnt, ridle, rid, rv};

endmodule

`default_nettype wire

// ----- src/teq_checker.sv -----
// ---------------------------------------------------------------------------
// teq_port_checker: port-level checks for the timer event queue
// Watches the stream ports and their ordering over time.
// ---------------------------------------------------------------------------
`default_nettype none

module teq_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata
);

	// a result never appears right after an accepted word
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid || $past(m_tvalid))
		else $error("result too early");

	// busy after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready after accept");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");

	// error code stays in range
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[69:68] != 2'd3)
		else $error("bad error code");

endmodule

bind timer_event_queue teq_port_checker u_teq_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

`default_nettype wire

// ----- dv/teq_checker.sv -----
// ---------------------------------------------------------------------------
// teq_checker: result predictor and scoreboard for the timer event queue
// Watches the input and result channels, keeps its own copy of the event
// table, predicts one result word per accepted input word and compares.
// ---------------------------------------------------------------------------
`default_nettype none

module teq_checker import teq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [95:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,
	output int               fail_count,
	output int               pending,
	output int               results_seen,
	output int               pops_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]            err;
		logic [CountBits-1:0]  rdy_cnt;
		logic [PeriodBits-1:0] idle;
		logic [3:0]            id;
		logic                  ev_valid;
	} teq_result_t;

	// table mirror
	logic                    ev_used  [MaxEvents];
	logic                    ev_ready [MaxEvents];
	logic [DueBits-1:0]      ev_due   [MaxEvents];
	logic [PriorityBits-1:0] ev_prio  [MaxEvents];
	logic [PeriodBits-1:0]   ev_per   [MaxEvents];
	logic                    ev_rep   [MaxEvents];
	logic [31:0]             ev_arr   [MaxEvents];
	logic [31:0]             arr_cnt;
	logic [TimeBits-1:0]     now;
	logic [31:0]             rdy_cnt;

	teq_result_t expected_results[$];

	// give slot a new due time and arrival number, file it as ready or timer
	task automatic reschedule(int s);
		ev_due[s] = {1'b0, now} + ev_per[s];
		ev_arr[s] = arr_cnt;
		arr_cnt++;
		if (ev_due[s] <= {1'b0, now}) begin
			ev_ready[s] = 1'b1;
			rdy_cnt++;
		end else
			ev_ready[s] = 1'b0;
	endtask

	function automatic bit orders_first(int a, int b);
		if (ev_due[a] != ev_due[b]) return ev_due[a] < ev_due[b];
		if (ev_prio[a] != ev_prio[b]) return ev_prio[a] < ev_prio[b];
		return ev_arr[a] < ev_arr[b];
	endfunction

	function automatic logic [PeriodBits-1:0] idle_after();
		bit have;
		logic [DueBits-1:0] best;
		have = 0;
		best = '0;
		for (int i = 0; i < MaxEvents; i++) begin
			if (!ev_used[i]) continue;
			if (ev_ready[i]) return '0;
			if (!have || ev_due[i] < best) begin
				best = ev_due[i];
				have = 1;
			end
		end
		if (!have) return '1;
		if (best <= {1'b0, now}) return '0;
		best = best - now;
		return (best > {1'b0, {PeriodBits{1'b1}}}) ? '1 : best[PeriodBits-1:0];
	endfunction

	task automatic predict_word(logic [95:0] w);
		logic [1:0] op;
		int id, pick;
		bit any, found;
		teq_result_t r;
		op = w[1:0];
		id = w[5:2];
		r = '0;
		any = 0;
		found = 0;
		pick = 0;
		case (op)
			OpCreate: begin
				if (id >= MaxEvents || ev_used[id]) r.err = ErrOccupied;
				else begin
					ev_used[id] = 1'b1;
					ev_per[id] = w[36:6];
					ev_prio[id] = w[44:37];
					ev_rep[id] = w[45];
					reschedule(id);
				end
			end
			OpRemove: begin
				if (id >= MaxEvents || !ev_used[id]) r.err = ErrEmpty;
				else begin
					ev_used[id] = 1'b0;
					ev_ready[id] = 1'b0;
				end
			end
			OpGetNext: begin
				for (int i = 0; i < MaxEvents; i++)
					if (ev_used[i] && ev_ready[i]) any = 1;
				// promote due timers only when nothing is ready
				if (!any)
					for (int i = 0; i < MaxEvents; i++)
						if (ev_used[i] && !ev_ready[i] && ev_due[i] <= {1'b0, now}) begin
							ev_ready[i] = 1'b1;
							rdy_cnt++;
						end
				for (int i = 0; i < MaxEvents; i++)
					if (ev_used[i] && ev_ready[i] && (!found || orders_first(i, pick))) begin
						pick = i;
						found = 1;
					end
				if (found) begin
					r.ev_valid = 1'b1;
					r.id = pick[3:0];
					if (ev_rep[pick]) reschedule(pick);
					else begin
						ev_used[pick] = 1'b0;
						ev_ready[pick] = 1'b0;
					end
				end
			end
			default: now = w[93:46];
		endcase
		r.idle = idle_after();
		r.rdy_cnt = rdy_cnt;
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		teq_result_t got, exp_r;
		if (!arst_n) begin
			for (int i = 0; i < MaxEvents; i++) begin
				ev_used[i] = 0; ev_ready[i] = 0; ev_due[i] = '0; ev_prio[i] = '0;
				ev_per[i] = '0; ev_rep[i] = 0; ev_arr[i] = '0;
			end
			arr_cnt = '0;
			now = '0;
			rdy_cnt = '0;
			expected_results.delete();
			fail_count = 0;
			results_seen = 0;
			pops_seen = 0;
		end else begin
			// compare the result word first, then predict the new input word
			if (m_tvalid && m_tready) begin
				got = m_tdata[69:0];
				results_seen++;
				if (got.ev_valid) pops_seen++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word %h", m_tdata);
				end else begin
					exp_r = expected_results.pop_front();
					if (got != exp_r || m_tdata[71:70] != 2'b00) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp valid=%0d id=%0d idle=%0d cnt=%0d err=%0d",
								" / got valid=%0d id=%0d idle=%0d cnt=%0d err=%0d"},
								exp_r.ev_valid, exp_r.id, exp_r.idle, exp_r.rdy_cnt,
								exp_r.err, got.ev_valid, got.id, got.idle, got.rdy_cnt,
								got.err);
					end
				end
			end
			if (s_tvalid && s_tready) predict_word(s_tdata);
		end
		pending = expected_results.size();
	end

endmodule

`default_nettype wire

// ----- dv/tb_timer_event_queue.sv -----
// ---------------------------------------------------------------------------
// tb_timer_event_queue: stimulus and verdict for the timer event queue
// Drives directed and random opcode words with random gaps and result
// stalls; the checker predicts and compares every result word.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_timer_event_queue;
	import teq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	int          fail_count, pending, results_seen, pops_seen;
	int          cycle_count;
	bit          stall_on;
	logic [TimeBits-1:0] tb_now;

	timer_event_queue i_dut (.*);

	teq_checker i_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// timeout watchdog: allows for the slowest word plus the input gap and the result stall
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 1500 * 120 * 4) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// result side: random stall before each word, with stall-free stretches
	initial begin
		int wait_n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			wait_n = stall_on ? $urandom_range(0, 18) : 0;
			if (wait_n > 0) begin
				m_tready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [95:0] pack_word(logic [1:0] op, int unsigned id,
		int unsigned per, int unsigned prio, int unsigned rep, longint unsigned tv);
		return {2'b00, 48'(tv), 1'(rep), 8'(prio), 31'(per), 4'(id), op};
	endfunction

	// hold the word valid until taken; drop valid only for a gap
	task automatic send(logic [95:0] w);
		int gap;
		gap = stall_on ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
	endtask

	// random word: mostly creates and get-nexts with small periods near now
	task automatic send_random();
		logic [1:0]  op;
		logic [30:0] per;
		logic [47:0] tv;
		int pick;
		pick = $urandom_range(0, 99);
		op = pick < 35 ? OpCreate : pick < 50 ? OpRemove : pick < 88 ? OpGetNext : OpSetTime;
		case ($urandom_range(0, 9))
			0: per = '0;
			1: per = 31'($urandom >> 1);
			2: per = 31'h7fffffff;
			default: per = 31'($urandom_range(0, 40));
		endcase
		case ($urandom_range(0, 9))
			0: tv = 48'({$urandom, $urandom});
			1: tv = tb_now - 48'($urandom_range(0, 30));
			default: tv = tb_now + 48'($urandom_range(0, 30));
		endcase
		if (op == OpSetTime) tb_now = tv;
		send(pack_word(op, $urandom_range(0, 15), per, $urandom_range(0, 3) == 0 ?
			$urandom : $urandom_range(0, 3), $urandom, tv));
	endtask

	initial begin
		s_tvalid = 0;
		s_tdata  = '0;
		stall_on = 0;
		tb_now   = '0;
		arst_n   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty get-next, remove of empty slot, extremes, ties
		send(pack_word(OpGetNext, 0, 0, 0, 0, 0));
		send(pack_word(OpRemove, 15, 0, 0, 0, 0));
		send(pack_word(OpCreate, 0, 0, 8'hff, 0, '1));
		send(pack_word(OpCreate, 0, 5, 0, 0, 0));
		send(pack_word(OpCreate, 15, 31'h7fffffff, 0, 1, 0));
		send(pack_word(OpCreate, 3, 0, 8'h00, 1, 0));
		send(pack_word(OpCreate, 4, 0, 8'h00, 0, 0));
		send(pack_word(OpGetNext, 0, 0, 0, 0, 0));
		send(pack_word(OpGetNext, 0, 0, 0, 0, 0));
		send(pack_word(OpGetNext, 0, 0, 0, 0, 0));
		send(pack_word(OpRemove, 3, 0, 0, 0, 0));
		send(pack_word(OpCreate, 5, 10, 2, 1, 0));
		send(pack_word(OpCreate, 6, 10, 1, 0, 0));
		send(pack_word(OpSetTime, 0, 0, 0, 0, 48'd20));
		send(pack_word(OpGetNext, 0, 0, 0, 0, 0));
		send(pack_word(OpGetNext, 0, 0, 0, 0, 0));
		send(pack_word(OpSetTime, 0, 0, 0, 0, 48'd5));
		send(pack_word(OpGetNext, 0, 0, 0, 0, 0));
		send(pack_word(OpSetTime, 0, 0, 0, 0, 48'hffffffffffff));
		send(pack_word(OpGetNext, 0, 0, 0, 0, 0));
		send(pack_word(OpSetTime, 0, 0, 0, 0, 48'h0));
		tb_now = 0;

		// random: phases with and without stalls
		for (int i = 0; i < 1200; i++) begin
			if (i % 150 == 0) stall_on = !stall_on;
			send_random();
		end
		s_tvalid <= 0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d result words, %0d of them popped events", results_seen, pops_seen);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
